/* rtl/rqst_pkg.sv */
// Shared types and constants for the requester slot table.
// Holds the beat structs, command codes and the per-cell control struct.
// No dependencies.
package rqst_pkg;

  // Field widths fixed by the interface
  localparam int unsigned IdW   = 15;
  localparam int unsigned SlotW = 8;

  // Command codes
  localparam logic CmdClaim   = 1'b0;
  localparam logic CmdRelease = 1'b1;

  typedef logic [IdW-1:0]   id_t;
  typedef logic [SlotW-1:0] slot_t;

  // Input beat
  typedef struct packed {
    logic command;
    id_t  requester_id;
  } req_t;

  // Output beat
  typedef struct packed {
    slot_t slot;
    slot_t high_water;
  } rsp_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic shift;
    logic write;
  } cell_ctl_t;

endpackage

/* rtl/rqst_cell.sv */
// One table entry of the requester slot ring.
// Depends on rqst_pkg for the entry type and the cell control struct.
// Rotates toward its neighbor on shift, loads the requester id on write.
module rqst_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rqst_pkg::cell_ctl_t ctl_i,
  input  rqst_pkg::id_t      shift_data_i,
  input  rqst_pkg::id_t      write_data_i,
  output rqst_pkg::id_t      data_o
);

  rqst_pkg::id_t entry_q, entry_d;

  // Write has priority; the sequencer never raises both
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.write) begin
      entry_d = write_data_i;
    end else if (ctl_i.shift) begin
      entry_d = shift_data_i;
    end
  end

  // Entries come up free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign data_o = entry_q;

endmodule

/* rtl/requester_slot_table_unit.sv */
// Requester slot table: ring of entry cells plus the scan sequencer.
// Depends on rqst_pkg and rqst_cell.
//
//   channel | direction | handshake              | beat
//   --------+-----------+------------------------+-------------------------
//   in      | to block  | in_valid_i / in_stall_o | rqst_pkg::req_t
//   out     | from block| out_valid_o / out_stall_i| rqst_pkg::rsp_t
//
// Each beat is accepted, then makes a full lap of the entry ring past the single
// comparator at its head, and then commits.
// Reset clears every entry and the high-water mark at once; no sweep follows.
// A new beat is accepted while a result still waits on out_stall_i; the commit
// cycle holds until the output register is free.
module requester_slot_table_unit #(
  parameter int unsigned TABLE_SLOTS = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rqst_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rqst_pkg::rsp_t out_data_o
);

  localparam int unsigned IdxW     = $clog2(TABLE_SLOTS);
  localparam int unsigned NumCells = TABLE_SLOTS - 1;
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(TABLE_SLOTS - 1);
  localparam logic [IdxW-1:0] FirstIdx = IdxW'(1);

  typedef enum logic [1:0] {StIdle, StScan, StFinish} state_e;

  state_e          state_q;
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] mark_q, mark_d;
  logic            cmd_q;
  rqst_pkg::id_t   id_q;
  logic            found_q;
  logic [IdxW-1:0] found_at_q;
  logic [IdxW-1:0] free_at_q;
  logic [IdxW-1:0] top_q;
  logic            out_valid_q;
  rqst_pkg::rsp_t  out_data_q;

  rqst_pkg::id_t       cell_data [NumCells];
  rqst_pkg::cell_ctl_t cell_ctl  [NumCells];

  rqst_pkg::id_t   head;
  rqst_pkg::id_t   feedback;
  logic            in_range, hit, is_free;
  logic            out_free, finish_fire, in_fire;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [IdxW-1:0] res_slot;

  // Head of ring holds entry idx_q during the lap
  assign head     = cell_data[0];
  assign in_range = (idx_q <= mark_q);
  assign hit      = (head == id_q);
  assign is_free  = (head == '0);

  // Release clears a matching entry as it wraps to the tail
  assign feedback = (cmd_q == rqst_pkg::CmdRelease && in_range && hit) ? '0 : head;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign finish_fire = (state_q == StFinish) && out_free;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != StIdle);

  // Commit decision once the lap is done
  always_comb begin
    wr_en    = 1'b0;
    wr_idx   = free_at_q;
    mark_d   = mark_q;
    res_slot = '0;
    if (cmd_q == rqst_pkg::CmdClaim) begin
      if (found_q) begin
        res_slot = found_at_q;
      end else if (free_at_q < mark_q) begin
        wr_en    = 1'b1;
        res_slot = free_at_q;
      end else if (mark_q != LastIdx) begin
        wr_en    = 1'b1;
        wr_idx   = mark_q + FirstIdx;
        mark_d   = mark_q + FirstIdx;
        res_slot = mark_q + FirstIdx;
      end
    end else if (top_q < mark_q) begin
      mark_d = top_q;
    end
  end

  // Entry ring: cell k holds entry k+1 when at home
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    rqst_pkg::id_t shift_in;
    if (k == NumCells - 1) begin : g_tail
      assign shift_in = feedback;
    end else begin : g_body
      assign shift_in = cell_data[k+1];
    end

    assign cell_ctl[k].shift = (state_q == StScan);
    assign cell_ctl[k].write = finish_fire && wr_en && (wr_idx == IdxW'(k + 1));

    rqst_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (cell_ctl[k]),
      .shift_data_i (shift_in),
      .write_data_i (id_q),
      .data_o       (cell_data[k])
    );
  end

  // Sequencer, scan trackers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mark_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      idx_q       <= FirstIdx;
      cmd_q       <= rqst_pkg::CmdClaim;
      id_q        <= '0;
      found_q     <= 1'b0;
      found_at_q  <= '0;
      free_at_q   <= '0;
      top_q       <= '0;
    end else begin
      // Output valid: set on commit, cleared when the beat leaves
      if (finish_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            cmd_q     <= in_data_i.command;
            id_q      <= in_data_i.requester_id;
            found_q   <= 1'b0;
            free_at_q <= mark_q;
            top_q     <= '0;
            idx_q     <= FirstIdx;
            state_q   <= StScan;
          end
        end
        StScan: begin
          if (in_range) begin
            if (cmd_q == rqst_pkg::CmdClaim) begin
              if (!found_q) begin
                if (hit) begin
                  found_q    <= 1'b1;
                  found_at_q <= idx_q;
                end else if (is_free) begin
                  free_at_q <= idx_q;
                end
              end
            end else if (!hit && !is_free) begin
              top_q <= idx_q;
            end
          end
          if (idx_q == LastIdx) begin
            state_q <= StFinish;
          end else begin
            idx_q <= idx_q + FirstIdx;
          end
        end
        StFinish: begin
          if (out_free) begin
            mark_q                <= mark_d;
            out_data_q.slot       <= rqst_pkg::slot_t'(res_slot);
            out_data_q.high_water <= rqst_pkg::slot_t'(mark_d);
            state_q               <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The mark moves only on commit
  a_mark_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !finish_fire |=> $stable(mark_q))
    else $error("high-water mark changed outside commit");

  // A result appears only out of the commit cycle
  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StFinish))
    else $error("result raised without commit");

  // Entries above the mark are always free
  a_free_above_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan && !in_range) |-> is_free)
    else $error("entry above high-water mark is in use");

  // The scan lap starts at the first entry
  a_lap_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (idx_q == FirstIdx))
    else $error("scan lap did not start at entry one");

endmodule
